// ----- rtl/core/ssg_pkg.sv -----
`timescale 1ns / 1ps
// shared widths, word layout and unit interface types for the smoothed stereo gain block
package ssg_pkg;

   localparam int SAMPLE_BITS    = 24;
   localparam int TARGET_BITS    = 24;
   localparam int TRIM_BITS      = 17;
   localparam int OP_BITS        = 32;
   localparam int PROD_BITS      = 2 * OP_BITS;
   localparam int NUM_BITS       = 2 * OP_BITS + 1;
   localparam int DEN_BITS       = OP_BITS + 1;
   localparam int STEP_BITS      = $clog2(OP_BITS);
   localparam int REQ_FIELD_BITS = 2 * SAMPLE_BITS + TARGET_BITS + TRIM_BITS;
   localparam int REQ_DATA_BITS  = (REQ_FIELD_BITS + 7) / 8 * 8;
   localparam int RSP_DATA_BITS  = (2 * SAMPLE_BITS + 7) / 8 * 8;

   typedef struct packed {
      logic               start;
      logic [OP_BITS-1:0] a;
      logic [OP_BITS-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic                 done;
      logic [PROD_BITS-1:0] product;
   } mul_rsp_type;

   typedef struct packed {
      logic                start;
      logic [NUM_BITS-1:0] num;
      logic [DEN_BITS-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [OP_BITS-1:0] quot;
      logic               rem_nz;
   } div_rsp_type;

endpackage

// ----- rtl/core/ssg_mul.sv -----
`timescale 1ns / 1ps
// bit-serial shift-add multiplier, one multiplier bit per cycle
module ssg_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  ssg_pkg::mul_req_type mul_req,
   output ssg_pkg::mul_rsp_type mul_rsp
);
   import ssg_pkg::*;

   localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(OP_BITS - 1);

   logic [PROD_BITS-1:0] prod_ff, prod_in;
   logic [OP_BITS-1:0]   mcand_ff, mcand_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [OP_BITS:0]     partial;

   assign partial = {1'b0, prod_ff[PROD_BITS-1:OP_BITS]}
                  + (prod_ff[0] ? {1'b0, mcand_ff} : {(OP_BITS + 1){1'b0}});

   always_comb begin
      prod_in  = prod_ff;
      mcand_in = mcand_ff;
      step_in  = step_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (mul_req.start) begin
         prod_in  = {{OP_BITS{1'b0}}, mul_req.b};
         mcand_in = mul_req.a;
         step_in  = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         prod_in = {partial, prod_ff[OP_BITS-1:1]};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      prod_ff  <= prod_in;
      mcand_ff <= mcand_in;
   end

   assign mul_rsp.done    = done_ff;
   assign mul_rsp.product = prod_ff;

endmodule

// ----- rtl/core/ssg_div.sv -----
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle
module ssg_div (
   input  logic                 clock,
   input  logic                 reset,
   input  ssg_pkg::div_req_type div_req,
   output ssg_pkg::div_rsp_type div_rsp
);
   import ssg_pkg::*;

   localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(OP_BITS - 1);

   logic [DEN_BITS-1:0]  rem_ff, rem_in;
   logic [OP_BITS-1:0]   quo_ff, quo_in;
   logic [DEN_BITS-1:0]  den_ff, den_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DEN_BITS:0]    trial;
   logic [DEN_BITS:0]    diff;
   logic                 fit;

   // remainder stays below the divisor, so one extra bit covers the shifted value
   assign trial = {rem_ff, quo_ff[OP_BITS-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fit   = ~diff[DEN_BITS];

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = div_req.num[NUM_BITS-1:OP_BITS];
         quo_in  = div_req.num[OP_BITS-1:0];
         den_in  = div_req.den;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fit ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
         quo_in  = {quo_ff[OP_BITS-2:0], fit};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign div_rsp.done   = done_ff;
   assign div_rsp.quot   = quo_ff;
   assign div_rsp.rem_nz = |rem_ff;

endmodule

// ----- rtl/core/smoothed_stereo_gain.sv -----
`timescale 1ns / 1ps
// smoothed stereo gain stage: chase-rate smoothing, trim smoothing and saturating scale
//
//  channel  dir  fields (lowest bits first)
//  req_     in   tdata: sample_left, sample_right, target_gain, trim_gain
//  rsp_     out  tdata: out_left, out_right; tuser: clipped
//
//  one word runs five multiplies and two divides, one after another on a single serial
//  multiplier and divider; the steps are accept, decay multiply, decay finish, then the
//  remaining multiplies and divides in turn, and last delivery
//  reset clears the chase rate to 350.0 and drops the primed state
//  a finished result waits in the output register; the next word is taken
//  meanwhile and holds in the last step until that register is free
module smoothed_stereo_gain (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // sample_left, sample_right, target_gain, trim_gain
   input  logic [ssg_pkg::REQ_DATA_BITS-1:0] req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_left, out_right
   output logic [ssg_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // clipped
   output logic                              rsp_tuser
);
   import ssg_pkg::*;

   localparam int SM_TRIM_BITS  = 24;
   localparam int TRIM_ACC_BITS = SM_TRIM_BITS + 12;
   localparam int SCALED_BITS   = PROD_BITS - 23;
   localparam int RIGHT_LSB     = SAMPLE_BITS;
   localparam int TARGET_LSB    = 2 * SAMPLE_BITS;
   localparam int TRIM_LSB      = TARGET_LSB + TARGET_BITS;

   localparam logic [OP_BITS-1:0]   RATE_ONE    = OP_BITS'(64'd1 << 20);
   localparam logic [OP_BITS-1:0]   RATE_FLOOR  = OP_BITS'(64'd350 << 20);
   localparam logic [OP_BITS:0]     RATE_CEIL   = (OP_BITS + 1)'(64'd2500 << 20);
   localparam logic [OP_BITS-1:0]   DECAY_Q30   = OP_BITS'(64'd1073634450);
   localparam logic [OP_BITS-1:0]   DECAY_STEP  = OP_BITS'(64'd10486);
   localparam logic [OP_BITS-1:0]   FLOOR_EDGE  = RATE_FLOOR + DECAY_STEP;
   localparam logic [DEN_BITS-1:0]  TRIM_DEN    = DEN_BITS'(64'd4001);
   localparam logic [PROD_BITS-1:0] HALF_RATE   = PROD_BITS'(64'd1 << 29);
   localparam logic [PROD_BITS-1:0] HALF_MIX    = PROD_BITS'(64'd1 << 24);
   localparam logic [PROD_BITS-1:0] HALF_SAMPLE = PROD_BITS'(64'd1 << 22);
   localparam logic [SCALED_BITS-1:0] SAT_NEG   = SCALED_BITS'(64'd1 << (SAMPLE_BITS - 1));
   localparam logic [SCALED_BITS-1:0] SAT_POS   = SAT_NEG - 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECAY,
      ST_DECAY_FIN,
      ST_GAIN_MUL,
      ST_GAIN_DIV,
      ST_TRIM_DIV,
      ST_MIX_MUL,
      ST_LEFT_MUL,
      ST_RIGHT_MUL,
      ST_DELIVER
   } state_type;

   function automatic logic [SAMPLE_BITS-1:0] magnitude(input logic [SAMPLE_BITS-1:0] x);
      magnitude = x[SAMPLE_BITS-1] ? (~x + 1'b1) : x;
   endfunction

   // returns {clip, sample}
   function automatic logic [SAMPLE_BITS:0] sat_scale(input logic [PROD_BITS-1:0] prod,
                                                      input logic neg);
      logic [PROD_BITS-1:0]   rnd;
      logic [SCALED_BITS-1:0] mag;
      logic [SCALED_BITS-1:0] lim;
      logic                   clip;
      logic [SAMPLE_BITS-1:0] val;
      rnd  = prod + HALF_SAMPLE;
      mag  = rnd[PROD_BITS-1:23];
      lim  = neg ? SAT_NEG : SAT_POS;
      clip = mag > lim;
      val  = clip ? lim[SAMPLE_BITS-1:0] : mag[SAMPLE_BITS-1:0];
      if (neg) begin
         val = ~val + 1'b1;
      end
      sat_scale = {clip, val};
   endfunction

   state_type                state_ff, state_in;
   logic                     primed_ff, primed_in;
   logic [OP_BITS-1:0]       rate_ff, rate_in;
   logic [OP_BITS-1:0]       sm_gain_ff, sm_gain_in;
   logic [SM_TRIM_BITS-1:0]  sm_trim_ff, sm_trim_in;
   logic [TARGET_BITS-1:0]   last_ff, last_in;
   logic [TARGET_BITS-1:0]   target_ff, target_in;
   logic [TRIM_BITS-1:0]     trim_ff, trim_in;
   logic [SAMPLE_BITS-1:0]   left_ff, left_in;
   logic [SAMPLE_BITS-1:0]   right_ff, right_in;
   logic                     up_ff, up_in;
   logic [OP_BITS-1:0]       mix_ff, mix_in;
   logic [SAMPLE_BITS-1:0]   out_left_ff, out_left_in;
   logic [SAMPLE_BITS-1:0]   out_right_ff, out_right_in;
   logic                     clip_ff, clip_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0]   rsp_left_ff, rsp_left_in;
   logic [SAMPLE_BITS-1:0]   rsp_right_ff, rsp_right_in;
   logic                     rsp_clip_ff, rsp_clip_in;
   mul_req_type              mul_req_ff, mul_req_in;
   div_req_type              div_req_ff, div_req_in;
   mul_rsp_type              mul_rsp;
   div_rsp_type              div_rsp;

   logic [TARGET_BITS-1:0]   req_target;
   logic [OP_BITS:0]         rate_pre;
   logic [OP_BITS-1:0]       rate_clamp;
   logic [PROD_BITS-1:0]     decay_sum;
   logic [OP_BITS-1:0]       rate_scaled;
   logic [OP_BITS-1:0]       rate_decayed;
   logic [OP_BITS-1:0]       target_q;
   logic [SM_TRIM_BITS-1:0]  trim_q;
   logic [NUM_BITS-1:0]      gain_num;
   logic [DEN_BITS-1:0]      gain_den;
   logic [OP_BITS-1:0]       gain_new;
   logic [TRIM_ACC_BITS-1:0] trim_acc;
   logic [NUM_BITS-1:0]      trim_num;
   logic [SM_TRIM_BITS-1:0]  trim_new;
   logic [PROD_BITS-1:0]     mix_sum;
   logic [OP_BITS-1:0]       mix_new;
   logic [SAMPLE_BITS:0]     left_sat;
   logic [SAMPLE_BITS:0]     right_sat;

   ssg_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req_ff),
      .mul_rsp (mul_rsp)
   );

   ssg_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req_ff),
      .div_rsp (div_rsp)
   );

   assign req_target = req_tdata[TRIM_LSB-1:TARGET_LSB];
   assign rate_pre   = (primed_ff && req_target != last_ff) ? {rate_ff, 1'b0}
                                                            : {1'b0, rate_ff};
   assign rate_clamp = (rate_pre > RATE_CEIL) ? RATE_CEIL[OP_BITS-1:0]
                                              : rate_pre[OP_BITS-1:0];

   assign decay_sum    = mul_rsp.product + HALF_RATE;
   assign rate_scaled  = decay_sum[OP_BITS+29:30];
   assign rate_decayed = (rate_scaled < FLOOR_EDGE) ? RATE_FLOOR : rate_scaled - DECAY_STEP;

   assign target_q = {target_ff, 8'b0};
   assign trim_q   = {trim_ff, 7'b0};
   assign gain_num = {1'b0, mul_rsp.product}
                   + {{(NUM_BITS - OP_BITS - 20){1'b0}}, target_q, 20'b0};
   assign gain_den = {1'b0, rate_ff} + {1'b0, RATE_ONE};
   assign gain_new = div_rsp.quot + {{(OP_BITS - 1){1'b0}}, up_ff & div_rsp.rem_nz};

   // times 4000 as 4096 - 128 + 32
   assign trim_acc = {sm_trim_ff, 12'b0} - {5'b0, sm_trim_ff, 7'b0}
                   + {7'b0, sm_trim_ff, 5'b0};
   assign trim_num = {{(NUM_BITS - TRIM_ACC_BITS){1'b0}}, trim_acc}
                   + {{(NUM_BITS - SM_TRIM_BITS){1'b0}}, trim_q};
   assign trim_new = div_rsp.quot[SM_TRIM_BITS-1:0]
                   + {{(SM_TRIM_BITS - 1){1'b0}}, up_ff & div_rsp.rem_nz};

   assign mix_sum = mul_rsp.product + HALF_MIX;
   assign mix_new = mix_sum[OP_BITS+24:25];

   assign left_sat  = sat_scale(mul_rsp.product, left_ff[SAMPLE_BITS-1]);
   assign right_sat = sat_scale(mul_rsp.product, right_ff[SAMPLE_BITS-1]);

   always_comb begin
      state_in         = state_ff;
      primed_in        = primed_ff;
      rate_in          = rate_ff;
      sm_gain_in       = sm_gain_ff;
      sm_trim_in       = sm_trim_ff;
      last_in          = last_ff;
      target_in        = target_ff;
      trim_in          = trim_ff;
      left_in          = left_ff;
      right_in         = right_ff;
      up_in            = up_ff;
      mix_in           = mix_ff;
      out_left_in      = out_left_ff;
      out_right_in     = out_right_ff;
      clip_in          = clip_ff;
      rsp_valid_in     = rsp_valid_ff & ~rsp_tready;
      rsp_left_in      = rsp_left_ff;
      rsp_right_in     = rsp_right_ff;
      rsp_clip_in      = rsp_clip_ff;
      mul_req_in       = mul_req_ff;
      mul_req_in.start = 1'b0;
      div_req_in       = div_req_ff;
      div_req_in.start = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               left_in   = req_tdata[SAMPLE_BITS-1:0];
               right_in  = req_tdata[TARGET_LSB-1:RIGHT_LSB];
               target_in = req_target;
               trim_in   = req_tdata[TRIM_LSB+TRIM_BITS-1:TRIM_LSB];
               last_in   = req_target;
               rate_in   = rate_clamp;
               if (!primed_ff) begin
                  sm_gain_in = {req_target, 8'b0};
                  sm_trim_in = {req_tdata[TRIM_LSB+TRIM_BITS-1:TRIM_LSB], 7'b0};
                  primed_in  = 1'b1;
               end
               mul_req_in = '{start: 1'b1, a: rate_clamp, b: DECAY_Q30};
               state_in   = ST_DECAY;
            end
         end
         ST_DECAY: begin
            if (mul_rsp.done) begin
               state_in = ST_DECAY_FIN;
            end
         end
         ST_DECAY_FIN: begin
            rate_in    = rate_decayed;
            mul_req_in = '{start: 1'b1, a: sm_gain_ff, b: rate_decayed};
            state_in   = ST_GAIN_MUL;
         end
         ST_GAIN_MUL: begin
            if (mul_rsp.done) begin
               up_in      = target_q >= sm_gain_ff;
               div_req_in = '{start: 1'b1, num: gain_num, den: gain_den};
               state_in   = ST_GAIN_DIV;
            end
         end
         ST_GAIN_DIV: begin
            if (div_rsp.done) begin
               sm_gain_in = gain_new;
               up_in      = trim_q >= sm_trim_ff;
               div_req_in = '{start: 1'b1, num: trim_num, den: TRIM_DEN};
               state_in   = ST_TRIM_DIV;
            end
         end
         ST_TRIM_DIV: begin
            if (div_rsp.done) begin
               sm_trim_in = trim_new;
               mul_req_in = '{start: 1'b1, a: sm_gain_ff, b: OP_BITS'(trim_new)};
               state_in   = ST_MIX_MUL;
            end
         end
         ST_MIX_MUL: begin
            if (mul_rsp.done) begin
               mix_in     = mix_new;
               mul_req_in = '{start: 1'b1, a: OP_BITS'(magnitude(left_ff)), b: mix_new};
               state_in   = ST_LEFT_MUL;
            end
         end
         ST_LEFT_MUL: begin
            if (mul_rsp.done) begin
               out_left_in = left_sat[SAMPLE_BITS-1:0];
               clip_in     = left_sat[SAMPLE_BITS];
               mul_req_in  = '{start: 1'b1, a: OP_BITS'(magnitude(right_ff)), b: mix_ff};
               state_in    = ST_RIGHT_MUL;
            end
         end
         ST_RIGHT_MUL: begin
            if (mul_rsp.done) begin
               out_right_in = right_sat[SAMPLE_BITS-1:0];
               clip_in      = clip_ff | right_sat[SAMPLE_BITS];
               state_in     = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_left_in  = out_left_ff;
               rsp_right_in = out_right_ff;
               rsp_clip_in  = clip_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         primed_ff    <= 1'b0;
         rate_ff      <= RATE_FLOOR;
         rsp_valid_ff <= 1'b0;
         mul_req_ff   <= '0;
         div_req_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         primed_ff    <= primed_in;
         rate_ff      <= rate_in;
         rsp_valid_ff <= rsp_valid_in;
         mul_req_ff   <= mul_req_in;
         div_req_ff   <= div_req_in;
      end
      sm_gain_ff   <= sm_gain_in;
      sm_trim_ff   <= sm_trim_in;
      last_ff      <= last_in;
      target_ff    <= target_in;
      trim_ff      <= trim_in;
      left_ff      <= left_in;
      right_ff     <= right_in;
      up_ff        <= up_in;
      mix_ff       <= mix_in;
      out_left_ff  <= out_left_in;
      out_right_ff <= out_right_in;
      clip_ff      <= clip_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
      rsp_clip_ff  <= rsp_clip_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_clip_ff;

   always_comb begin
      rsp_tdata                          = '0;
      rsp_tdata[SAMPLE_BITS-1:0]         = rsp_left_ff;
      rsp_tdata[TARGET_LSB-1:RIGHT_LSB]  = rsp_right_ff;
   end

endmodule
